@@ rtl/core/prt_pkg.sv @@
// ----------------------------------------------------------------------------
// prt_pkg
// Shared types and constants of the probe response tracker.
// ----------------------------------------------------------------------------
package prt_pkg;

  localparam int TRACK_DEPTH = 1024;
  localparam int OPEN_LIMIT  = 1024;
  localparam int IDX_W       = $clog2(TRACK_DEPTH);
  localparam int CNT_W       = 11;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] SRC_PORT_BASE = 16'd12345;
  localparam logic [15:0] SRC_PORT_MOD  = 16'd10000;
  localparam logic [7:0]  ICMP_UNREACH  = 8'd3;
  localparam logic [7:0]  ICMP_PORT_UNR = 8'd3;

  // input modes
  localparam logic [1:0] MODE_PROBE = 2'd0;
  localparam logic [1:0] MODE_REPLY = 2'd1;
  localparam logic [1:0] MODE_SWEEP = 2'd2;

  // configuration register indexes
  localparam logic CFG_SCAN_KIND = 1'b0;
  localparam logic CFG_TARGET    = 1'b1;

  // result kinds
  localparam logic [2:0] RK_NOTHING  = 3'd0;
  localparam logic [2:0] RK_RECORDED = 3'd1;
  localparam logic [2:0] RK_OPEN     = 3'd2;
  localparam logic [2:0] RK_CLOSED   = 3'd3;
  localparam logic [2:0] RK_OPEN_FLT = 3'd4;
  localparam logic [2:0] RK_NO_MATCH = 3'd5;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] port_number;
    logic [31:0] sequence_value;
    logic [31:0] source_address;
    logic        flag_syn;
    logic        flag_ack;
    logic        flag_rst;
    logic [7:0]  icmp_type_field;
    logic [7:0]  icmp_code_field;
    logic [9:0]  entry_index;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [15:0] matched_port;
    logic [15:0] reset_source_port;
    logic [31:0] reset_sequence;
    logic [31:0] reset_acknowledge;
    logic        open_recorded;
    logic [10:0] open_total;
  } out_item_t;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_PROBE,
    OP_REPLY_TCP,
    OP_REPLY_UDP,
    OP_SWEEP,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] port;
    logic [15:0] derived_port;
    logic [31:0] seq;
    logic        syn;
    logic        ack;
    logic        rst;
    logic [IDX_W-1:0] index;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_READ,
    ST_DONE
  } back_state_t;

  // 12345 + (port mod 10000), mod 2^16; quotient of port/10000 is 0..6
  function automatic logic [15:0] derive_src_port(input logic [15:0] port);
    logic [15:0] r;
    r = port;
    for (int i = 0; i < 6; i++) begin
      if (r >= SRC_PORT_MOD) r = r - SRC_PORT_MOD;
    end
    return SRC_PORT_BASE + r;
  endfunction

endpackage

@@ rtl/core/probe_response_tracker_unit.sv @@
// Flow: probe and ignored beats are answered from the output register; a sweep reads one
//   table entry; a reply search runs the single-port table scan (one entry a cycle).
// Throughput: probe one beat a cycle while the receiver takes results; the back end runs
//   one beat at a time, a 2-entry queue buffers input.
// Reset: synchronous; a clearing pass over all TRACK_DEPTH (1024) entries zeroes the
//   table, during which no beat is executed (configuration writes are taken).
// ----------------------------------------------------------------------------
// probe_response_tracker_unit
// Probe/reply matcher with a ring tracking table.
// ----------------------------------------------------------------------------
module probe_response_tracker_unit
  import prt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data
);

  logic        scan_kind;
  logic [31:0] target_address;
  logic        cmd_valid, cmd_ready;
  cmd_t        cmd_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_kind      <= 1'b0;
      target_address <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SCAN_KIND: scan_kind      <= cfg_data[0];
        CFG_TARGET:    target_address <= cfg_data;
        default: ;
      endcase
    end
  end

  prt_front u_front (
    .clk, .rst, .scan_kind, .target_address,
    .in_valid, .in_ready, .in_data,
    .cmd_valid, .cmd_ready, .cmd_data
  );

  prt_back u_back (
    .clk, .rst, .cmd_valid, .cmd_ready, .cmd_data,
    .out_valid, .out_ready, .out_data
  );

endmodule

@@ rtl/core/prt_front.sv @@
// ----------------------------------------------------------------------------
// prt_front
// Accepts input beats, classifies them and fills a short command queue.
// ----------------------------------------------------------------------------
module prt_front
  import prt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     scan_kind,
  input  logic [31:0] target_address,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd_data
);

  cmd_t q [QUEUE_DEPTH];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       fill;
  cmd_t             cls;
  logic             push, pop;

  // classify one beat
  always_comb begin
    cls              = '0;
    cls.port         = in_data.port_number;
    cls.derived_port = derive_src_port(in_data.port_number);
    cls.seq          = in_data.sequence_value;
    cls.syn          = in_data.flag_syn;
    cls.ack          = in_data.flag_ack;
    cls.rst          = in_data.flag_rst;
    cls.index        = in_data.entry_index[IDX_W-1:0];
    unique case (in_data.mode)
      MODE_PROBE: cls.op = OP_PROBE;
      MODE_REPLY: begin
        if (!scan_kind)
          cls.op = (in_data.source_address == target_address) ? OP_REPLY_TCP : OP_NONE;
        else
          cls.op = (in_data.icmp_type_field == ICMP_UNREACH &&
                    in_data.icmp_code_field == ICMP_PORT_UNR) ? OP_REPLY_UDP : OP_NONE;
      end
      MODE_SWEEP: cls.op = OP_SWEEP;
      default:    cls.op = OP_NONE;
    endcase
  end

  assign in_ready  = (fill != 2'(QUEUE_DEPTH));
  assign cmd_valid = (fill != 2'd0);
  assign cmd_data  = q[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/core/prt_back.sv @@
// ----------------------------------------------------------------------------
// prt_back
// Executes commands against the tracking table: probe writes, linear reply
// search and sweep reads. Holds one output register.
// ----------------------------------------------------------------------------
module prt_back
  import prt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_ready,
  input  cmd_t      cmd_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  typedef struct packed {
    logic [15:0] port;
    logic [15:0] derived_port;
    logic [31:0] seq;
    logic        answered;
  } entry_t;

  entry_t mem [TRACK_DEPTH];
  entry_t rd_entry;

  back_state_t state, state_next;
  cmd_t        cur;
  logic [IDX_W-1:0] ptr;        // clear address / next scan address
  logic [IDX_W-1:0] rd_sel;     // address read this cycle
  logic [IDX_W-1:0] rd_addr;    // address held in rd_entry
  logic             rd_pending;
  logic [IDX_W-1:0] wr_pos;
  logic [CNT_W-1:0] open_cnt;
  logic             take;
  logic             hit;
  logic             scan_last;
  logic             out_valid_next;
  out_item_t        out_data_next;

  assign take      = (state == ST_IDLE) && cmd_valid && (!out_valid || out_ready);
  assign cmd_ready = take;
  assign hit       = rd_pending && rd_entry.port == cur.port && rd_entry.port != 16'd0 &&
                     !rd_entry.answered;
  assign scan_last = rd_pending && rd_addr == IDX_W'(TRACK_DEPTH - 1);

  // first read of a command goes out on the take edge
  assign rd_sel = !take ? ptr : (cmd_data.op == OP_SWEEP) ? cmd_data.index : '0;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (ptr == IDX_W'(TRACK_DEPTH - 1)) state_next = ST_IDLE;
      ST_IDLE: begin
        if (take) begin
          unique case (cmd_data.op)
            OP_REPLY_TCP, OP_REPLY_UDP:
              state_next = (cmd_data.port == 16'd0) ? ST_DONE : ST_SCAN;
            OP_SWEEP: state_next = ST_READ;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: if (hit || scan_last) state_next = ST_IDLE;
      ST_READ: if (rd_pending) state_next = ST_IDLE;
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  // table write and registered read
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR)
      mem[ptr] <= '0;
    else if (take && cmd_data.op == OP_PROBE)
      mem[wr_pos] <= '{cmd_data.port, cmd_data.derived_port, cmd_data.seq, 1'b0};
    else if (state == ST_SCAN && hit &&
             (cur.op == OP_REPLY_UDP || (cur.syn && cur.ack) || cur.rst))
      mem[rd_addr] <= '{rd_entry.port, rd_entry.derived_port, rd_entry.seq, 1'b1};
    rd_entry <= mem[rd_sel];
  end

  // control: pointers, counters, command register
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      rd_pending <= 1'b0;
      wr_pos     <= '0;
      open_cnt   <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          ptr        <= ptr + 1'b1;
          rd_pending <= 1'b0;
        end
        ST_IDLE: begin
          rd_pending <= take && ((cmd_data.op == OP_SWEEP) ||
                        ((cmd_data.op == OP_REPLY_TCP || cmd_data.op == OP_REPLY_UDP) &&
                         cmd_data.port != 16'd0));
          if (take) begin
            cur <= cmd_data;
            if (cmd_data.op == OP_PROBE) wr_pos <= wr_pos + 1'b1;
            if (cmd_data.op == OP_SWEEP) ptr <= cmd_data.index;
            else                         ptr <= IDX_W'(1);
          end
        end
        ST_SCAN: begin
          rd_pending <= !(hit || scan_last);
          if (!(hit || scan_last)) ptr <= ptr + 1'b1;
          if (hit && cur.op == OP_REPLY_TCP && cur.syn && cur.ack &&
              open_cnt < CNT_W'(OPEN_LIMIT))
            open_cnt <= open_cnt + 1'b1;
        end
        ST_READ: begin
          rd_pending <= 1'b0;
          if (rd_pending && rd_entry.port != 16'd0 && !rd_entry.answered &&
              open_cnt < CNT_W'(OPEN_LIMIT))
            open_cnt <= open_cnt + 1'b1;
        end
        default: rd_pending <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rd_addr <= rd_sel;
  end

  // result next value
  always_comb begin
    out_valid_next = out_valid && !out_ready;
    out_data_next  = out_data;
    if (take && (cmd_data.op == OP_PROBE || cmd_data.op == OP_NONE)) begin
      out_valid_next            = 1'b1;
      out_data_next             = '0;
      out_data_next.open_total  = open_cnt;
      if (cmd_data.op == OP_PROBE) begin
        out_data_next.result_kind  = RK_RECORDED;
        out_data_next.matched_port = cmd_data.port;
      end
    end
    if (state == ST_DONE) begin
      out_valid_next            = 1'b1;
      out_data_next             = '0;
      out_data_next.result_kind = RK_NO_MATCH;
      out_data_next.open_total  = open_cnt;
    end
    if (state == ST_SCAN && (hit || scan_last)) begin
      out_valid_next           = 1'b1;
      out_data_next            = '0;
      out_data_next.open_total = open_cnt;
      if (!hit) begin
        out_data_next.result_kind = RK_NO_MATCH;
      end else begin
        out_data_next.matched_port = cur.port;
        if (cur.op == OP_REPLY_UDP) begin
          out_data_next.result_kind = RK_CLOSED;
        end else if (cur.syn && cur.ack) begin
          out_data_next.result_kind       = RK_OPEN;
          out_data_next.reset_source_port = rd_entry.derived_port;
          out_data_next.reset_sequence    = rd_entry.seq + 32'd1;
          out_data_next.reset_acknowledge = cur.seq + 32'd1;
          if (open_cnt < CNT_W'(OPEN_LIMIT)) begin
            out_data_next.open_recorded = 1'b1;
            out_data_next.open_total    = open_cnt + 1'b1;
          end
        end else if (cur.rst) begin
          out_data_next.result_kind = RK_CLOSED;
        end
      end
    end
    if (state == ST_READ && rd_pending) begin
      out_valid_next           = 1'b1;
      out_data_next            = '0;
      out_data_next.open_total = open_cnt;
      if (rd_entry.port != 16'd0 && !rd_entry.answered) begin
        out_data_next.result_kind  = RK_OPEN_FLT;
        out_data_next.matched_port = rd_entry.port;
        if (open_cnt < CNT_W'(OPEN_LIMIT)) begin
          out_data_next.open_recorded = 1'b1;
          out_data_next.open_total    = open_cnt + 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= out_valid_next;
    out_data <= out_data_next;
  end

endmodule

@@ rtl/core/prt_checker.sv @@
// ----------------------------------------------------------------------------
// prt_checker
// Port-level checks of the tracker.
// ----------------------------------------------------------------------------
module prt_checker
  import prt_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // beat holds while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // a counted open always reports open or open-or-filtered
  a_rec_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.open_recorded |->
      (out_data.result_kind == RK_OPEN || out_data.result_kind == RK_OPEN_FLT))
    else $error("open_recorded on wrong kind");

  // total never beyond limit
  a_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.open_total <= CNT_W'(OPEN_LIMIT))
    else $error("open total over limit");

  // reset source port and reset acknowledge only on open
  a_rst_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind != RK_OPEN |->
      out_data.reset_source_port == 16'd0 && out_data.reset_acknowledge == 32'd0)
    else $error("reset fields set on non-open result");

endmodule

bind probe_response_tracker_unit prt_checker u_prt_checker (
  .clk, .rst, .out_valid, .out_ready, .out_data
);

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the probe response tracker. A local table model
// predicts each result beat; random and directed probe, reply and sweep
// beats run under several idle and stall patterns and register settings.
// ----------------------------------------------------------------------------
import prt_pkg::*;

// Scoreboard: table model plus queue of predicted result beats
class tracker_scoreboard;
  logic [15:0] tbl_port [TRACK_DEPTH];
  logic [15:0] tbl_sport [TRACK_DEPTH];
  logic [31:0] tbl_seq [TRACK_DEPTH];
  bit          tbl_done [TRACK_DEPTH];
  int unsigned wr_pos;
  int unsigned open_cnt;
  bit          udp_scan;
  logic [31:0] target;
  out_item_t   pending [$];
  int          mismatches;
  int          checked;
  int          n_open, n_closed, n_flt, n_nomatch;

  function new();
    for (int i = 0; i < TRACK_DEPTH; i++) begin
      tbl_port[i] = '0; tbl_sport[i] = '0; tbl_seq[i] = '0; tbl_done[i] = 0;
    end
    wr_pos = 0; open_cnt = 0; udp_scan = 0; target = '0;
    mismatches = 0; checked = 0;
    n_open = 0; n_closed = 0; n_flt = 0; n_nomatch = 0;
  endfunction

  function void set_reg(logic idx, logic [31:0] val);
    if (idx == CFG_SCAN_KIND) udp_scan = val[0];
    else target = val;
  endfunction

  // first live unanswered entry with this port, -1 if none
  function int find_entry(logic [15:0] port);
    if (port == 0) return -1;
    for (int i = 0; i < TRACK_DEPTH; i++)
      if (tbl_port[i] == port && !tbl_done[i]) return i;
    return -1;
  endfunction

  function bit bump_open();
    if (open_cnt < OPEN_LIMIT) begin
      open_cnt++;
      return 1;
    end
    return 0;
  endfunction

  function void note_input(in_item_t b);
    out_item_t r;
    int at;
    r = '0;
    r.result_kind = RK_NOTHING;
    if (b.mode == MODE_PROBE) begin
      tbl_port[wr_pos] = b.port_number;
      tbl_sport[wr_pos] = 16'(12345 + (int'(b.port_number) % 10000));
      tbl_seq[wr_pos] = b.sequence_value;
      tbl_done[wr_pos] = 0;
      wr_pos = (wr_pos + 1) % TRACK_DEPTH;
      r.result_kind = RK_RECORDED;
      r.matched_port = b.port_number;
    end else if (b.mode == MODE_REPLY) begin
      if (!udp_scan) begin
        if (b.source_address == target) begin
          at = find_entry(b.port_number);
          if (at < 0) r.result_kind = RK_NO_MATCH;
          else begin
            r.matched_port = b.port_number;
            if (b.flag_syn && b.flag_ack) begin
              r.open_recorded = bump_open();
              tbl_done[at] = 1;
              r.result_kind = RK_OPEN;
              r.reset_source_port = tbl_sport[at];
              r.reset_sequence = tbl_seq[at] + 32'd1;
              r.reset_acknowledge = b.sequence_value + 32'd1;
            end else if (b.flag_rst) begin
              tbl_done[at] = 1;
              r.result_kind = RK_CLOSED;
            end
          end
        end
      end else if (b.icmp_type_field == 8'd3 && b.icmp_code_field == 8'd3) begin
        at = find_entry(b.port_number);
        if (at >= 0) begin
          tbl_done[at] = 1;
          r.result_kind = RK_CLOSED;
          r.matched_port = b.port_number;
        end else r.result_kind = RK_NO_MATCH;
      end
    end else if (b.mode == MODE_SWEEP) begin
      if (tbl_port[b.entry_index] != 0 && !tbl_done[b.entry_index]) begin
        r.result_kind = RK_OPEN_FLT;
        r.matched_port = tbl_port[b.entry_index];
        r.open_recorded = bump_open();
      end
    end
    r.open_total = 11'(open_cnt);
    case (r.result_kind)
      RK_OPEN:     n_open++;
      RK_CLOSED:   n_closed++;
      RK_OPEN_FLT: n_flt++;
      RK_NO_MATCH: n_nomatch++;
      default: ;
    endcase
    pending.push_back(r);
  endfunction

  function void check_result(out_item_t got);
    out_item_t exp;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result beat %p", got);
      return;
    end
    exp = pending.pop_front();
    checked++;
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on result %0d: expected %p got %p", checked, exp, got);
    end
  endfunction
endclass

module tb_top;
  localparam int CYCLE_LIMIT = 3000000;

  logic      clk = 0;
  logic      rst = 1;
  logic      cfg_we = 0;
  logic      cfg_index = 0;
  logic [31:0] cfg_data = '0;
  logic      in_valid = 0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 0;
  out_item_t out_data;

  tracker_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;
  int  cycles = 0;
  int  sent = 0;
  logic [15:0] recent_ports [8];

  always #5 clk = ~clk;

  probe_response_tracker_unit uut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data
  );

  // accepted beats update the model and check results at the rising edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_input(in_data);
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  // receiver: random stalls, or a forced hold-off
  always @(negedge clk) begin
    out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // cycle limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid stays up after a beat; idle gaps and drain() lower it
  task automatic send_beat(in_item_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    end
    in_valid <= 1;
    in_data <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
    sb.set_reg(idx, val);
  endtask

  // stop sending, wait for all results, then a full search time
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (TRACK_DEPTH + 8) @(negedge clk);
  endtask

  function automatic in_item_t rand_beat();
    in_item_t b;
    int pick;
    b = in_item_t'(111'({$urandom, $urandom, $urandom, $urandom}));
    pick = $urandom_range(99);
    if (pick < 40) b.mode = MODE_PROBE;
    else if (pick < 75) b.mode = MODE_REPLY;
    else if (pick < 95) b.mode = MODE_SWEEP;
    else b.mode = 2'd3;
    // mostly small port set so replies find their probes
    if ($urandom_range(9) < 8) b.port_number = recent_ports[$urandom_range(7)];
    if (b.mode == MODE_REPLY && $urandom_range(9) < 8) b.source_address = sb.target;
    if ($urandom_range(3) != 0) begin
      b.icmp_type_field = 8'd3;
      b.icmp_code_field = 8'd3;
    end
    if ($urandom_range(3) == 0) begin
      b.flag_syn = 1; b.flag_ack = 1;
    end
    if ($urandom_range(9) == 0) b.entry_index = sb.wr_pos[9:0] - 10'd1;
    return b;
  endfunction

  function automatic in_item_t mk(logic [1:0] m, logic [15:0] p, logic [31:0] s,
                                  logic [2:0] fl, logic [9:0] idx);
    in_item_t b;
    b = '0;
    b.mode = m; b.port_number = p; b.sequence_value = s;
    b.source_address = sb.target;
    {b.flag_syn, b.flag_ack, b.flag_rst} = fl;
    b.icmp_type_field = 8'd3; b.icmp_code_field = 8'd3;
    b.entry_index = idx;
    return b;
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle; recv_stall_pct = stall;
    repeat (n) send_beat(rand_beat());
  endtask

  initial begin
    in_item_t b;
    for (int i = 0; i < 8; i++) recent_ports[i] = 16'($urandom_range(1, 65535));
    recent_ports[0] = 16'd65535;
    repeat (4) @(negedge clk);
    rst <= 0;
    // registers are taken during the clearing pass
    write_reg(CFG_TARGET, 32'hFFFF_FFFF);

    // directed TCP cases
    send_beat(mk(MODE_SWEEP, 0, 0, 0, 10'd0));             // empty entry
    send_beat(mk(MODE_PROBE, 16'd65535, 32'hFFFF_FFFF, 0, 0));
    send_beat(mk(MODE_PROBE, 16'd0, 32'd0, 0, 0));          // empty probe
    send_beat(mk(MODE_PROBE, 16'd9999, 32'd7, 0, 0));
    send_beat(mk(MODE_PROBE, 16'd10000, 32'd8, 0, 0));
    send_beat(mk(MODE_PROBE, 16'd80, 32'd9, 0, 0));
    send_beat(mk(MODE_REPLY, 16'd0, 32'd1, 3'b110, 0));     // port zero no match
    send_beat(mk(MODE_REPLY, 16'd65535, 32'hFFFF_FFFF, 3'b110, 0)); // open, wrap
    send_beat(mk(MODE_REPLY, 16'd65535, 32'd5, 3'b110, 0)); // answered: no match
    send_beat(mk(MODE_REPLY, 16'd9999, 32'd1, 3'b001, 0));  // RST closed
    send_beat(mk(MODE_REPLY, 16'd10000, 32'd1, 3'b100, 0)); // SYN only
    send_beat(mk(MODE_REPLY, 16'd10000, 32'd1, 3'b111, 0)); // SYN+ACK wins
    b = mk(MODE_REPLY, 16'd80, 32'd1, 3'b110, 0);
    b.source_address = 32'h0;                                 // other host
    send_beat(b);
    send_beat(mk(MODE_SWEEP, 0, 0, 0, 10'd4));               // live entry
    send_beat(mk(MODE_SWEEP, 0, 0, 0, 10'd1023));
    send_beat(mk(2'd3, 16'd80, 0, 3'b111, 10'd4));            // unused mode
    drain();

    // directed UDP cases
    write_reg(CFG_SCAN_KIND, 32'd1);
    write_reg(CFG_TARGET, 32'd0);
    send_beat(mk(MODE_PROBE, 16'd53, 32'd1, 0, 0));
    b = mk(MODE_REPLY, 16'd53, 0, 0, 0); b.icmp_code_field = 8'd1;
    send_beat(b);                                             // not port unreachable
    b = mk(MODE_REPLY, 16'd53, 0, 0, 0); b.source_address = 32'h1234;
    send_beat(b);                                             // closed, any source
    send_beat(mk(MODE_REPLY, 16'd53, 0, 0, 0));               // no match
    drain();

    // random phases over settings and idle patterns
    write_reg(CFG_SCAN_KIND, 32'd0);
    write_reg(CFG_TARGET, $urandom);
    random_phase(120, 0, 0);
    random_phase(90, 69, 0);
    drain();
    write_reg(CFG_SCAN_KIND, 32'd1);
    random_phase(90, 0, 69);
    random_phase(60, 30, 30);
    drain();
    write_reg(CFG_SCAN_KIND, 32'd0);
    write_reg(CFG_TARGET, 32'd0);
    random_phase(80, 30, 30);

    // long receiver hold-off so the input queue backs up
    send_idle_pct = 0;
    fork
      begin
        hold_off = 1;
        repeat (200) @(negedge clk);
        hold_off = 0;
      end
      repeat (30) send_beat(mk(MODE_PROBE, recent_ports[$urandom_range(7)],
                               $urandom, 0, 0));
    join
    random_phase(100, 0, 0);

    drain();
    $display("sent %0d beats, checked %0d results over TCP and UDP settings", sent, sb.checked);
    $display("open %0d closed %0d open-or-filtered %0d no-match %0d, final open count %0d",
             sb.n_open, sb.n_closed, sb.n_flt, sb.n_nomatch, sb.open_cnt);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
